>>> hw/rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg: shared types, constants and helpers
// Beat layouts, lane status, coefficient bundle and fixed-point helpers
// for the stereo ladder low-pass.
// ----------------------------------------------------------------------------
package sll_pkg;

    localparam int NUM_STAGES   = 4;
    localparam int NUM_CHANNELS = 2;
    localparam int NUM_LANES    = (NUM_CHANNELS < 2) ? NUM_CHANNELS : 2;
    localparam int STG_W        = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = CFG_IDX_W'(1);

    localparam logic [14:0] CUTOFF_RESET = 15'd440;

    // pi in Q24 split as 24000 * PI_INT + PI_FRAC
    localparam logic [11:0] PI_INT  = 12'd2196;
    localparam logic [11:0] PI_FRAC = 12'd3179;
    // ceil(2^42 / 24000), exact for dividends below 2^27
    localparam logic [27:0] RECIP24K = 28'd183251938;

    localparam logic signed [31:0] K_G1 = 32'sd16596022;
    localparam logic signed [31:0] K_G2 = 32'sd7284667;
    localparam logic signed [31:0] K_G3 = 32'sd2316934;
    localparam logic signed [31:0] K_G4 = 32'sd338900;
    localparam logic signed [31:0] K_C0 = 32'sd16825870;
    localparam logic signed [31:0] K_C1 = 32'sd882482;
    localparam logic signed [31:0] K_C2 = 32'sd1553570;
    localparam logic signed [31:0] K_C3 = 32'sd365744;

    // reciprocal of 13 scaled by 2^26, rounded up
    localparam logic [22:0] RECIP13 = 23'd5162221;
    // 13 * 2^31, keeps the dividend non-negative
    localparam logic signed [37:0] DIV_OFS = 38'sd27917287424;

    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } out_beat_t;

    typedef struct packed {
        logic [17:0] gain;
        logic [19:0] fb;
    } coef_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [23:0] result;
    } lane_stat_t;

    typedef struct packed {
        logic [17:0] q;
        logic [3:0]  r;
    } div13_t;

    function automatic div13_t div13_step(input logic [21:0] v);
        logic [44:0] p;
        logic [21:0] back;
        div13_t      d;
        p    = 45'(v) * 45'(RECIP13);
        d.q  = p[43:26];
        back = 22'(d.q) * 22'd13;
        d.r  = 4'(v - back);
        return d;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] o;
        if (v > 39'sd2147483647)
        begin
            o = 32'sh7fffffff;
        end
        else if (v < -39'sd2147483648)
        begin
            o = 32'sh80000000;
        end
        else
        begin
            o = v[31:0];
        end
        return o;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
        logic signed [23:0] o;
        if (v > 29'sd8388607)
        begin
            o = 24'sh7fffff;
        end
        else if (v < -29'sd8388608)
        begin
            o = 24'sh800000;
        end
        else
        begin
            o = v[23:0];
        end
        return o;
    endfunction

endpackage

>>> hw/rtl/stereo_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// stereo_ladder_lowpass: stereo four-pole ladder low-pass
// One lane per channel works through feedback and four stages; the results
// merge into one output register.
// ----------------------------------------------------------------------------
// An item runs through the resonance feedback, then through each stage in
// turn (a two-digit divide by thirteen, then the gain multiply) on each
// lane's single multiplier, and the result then loads the output register.
// The next item is not accepted before the lane result has been loaded into
// the output register, and that load waits while the output is stalled. A
// register write reruns the coefficient derivation, which also runs after
// reset; input is stalled and cfg_ready is low while it runs.
module stereo_ladder_lowpass
    import sll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    coef_t      coef;
    lane_stat_t lane_stat [NUM_LANES];
    logic       start, load;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_data_reg, merged;

    sll_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .coef      (coef)
    );

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        sll_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .ack    (load),
            .sample ((c == 0) ? in_data.left_in : in_data.right_in),
            .coef   (coef),
            .stat   (lane_stat[c])
        );
    end

    assign in_stall = lane_stat[0].busy | ~cfg_ready;
    assign start    = in_valid & ~in_stall;
    assign load     = lane_stat[0].done & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        merged.left_out  = lane_stat[0].result;
        merged.right_out = (NUM_LANES > 1) ? lane_stat[NUM_LANES-1].result : '0;
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/sll_coef.sv
// ----------------------------------------------------------------------------
// sll_coef: register file and coefficient derivation
// Holds cutoff and resonance, and derives the stage gain and the feedback
// coefficient with one shared multiplier and a reciprocal divide by 24000.
// ----------------------------------------------------------------------------
module sll_coef
    import sll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_ready,
    output coef_t                 coef
);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_NUM  = 7'b0000010,
        C_DIV  = 7'b0000100,
        C_MUL  = 7'b0001000,
        C_ADD  = 7'b0010000,
        C_FBM  = 7'b0100000,
        C_FBA  = 7'b1000000
    } cstate_t;

    typedef struct packed {
        logic               use_b;
        logic signed [31:0] b_k;
        logic signed [31:0] k;
        logic               neg;
    } hstep_t;

    function automatic hstep_t hstep(input logic [2:0] st);
        hstep_t h;
        h = '0;
        case (st)
            3'd0:
            begin
                h.use_b = 1'b1;
                h.b_k   = K_G4;
                h.k     = K_G3;
                h.neg   = 1'b1;
            end
            3'd1:    h.k = -K_G2;
            3'd2:    h.k = K_G1;
            3'd3:    h.k = '0;
            3'd4:
            begin
                h.use_b = 1'b1;
                h.b_k   = K_C3;
                h.k     = -K_C2;
            end
            3'd5:    h.k = K_C1;
            3'd6:    h.k = K_C0;
            default: h = '0;
        endcase
        return h;
    endfunction

    cstate_t            state_reg, state_next;
    logic [14:0]        cutoff_reg, cutoff_next;
    logic [16:0]        res_reg, res_next;
    logic [26:0]        num_reg, num_next;
    logic [26:0]        quo_reg, quo_next;
    logic [2:0]         step_reg, step_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [19:0]        c16_reg, c16_next;
    logic [17:0]        gain_reg, gain_next;
    logic [19:0]        fb_reg, fb_next;

    hstep_t             hs;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [54:0]        rp;
    logic [26:0]        xq;
    logic signed [33:0] r24, tn;
    logic signed [25:0] sc;
    logic [39:0]        fsum;

    assign hs    = hstep(step_reg);
    assign mul_p = mul_a * mul_b;
    assign rp    = 55'(num_reg) * 55'(RECIP24K);
    assign xq    = 27'(cutoff_reg) * 27'(PI_INT) + 27'(rp[54:42]);
    assign r24   = 34'((prod_reg + 66'sd8388608) >>> 24);
    assign tn    = hs.neg ? (34'(hs.k) - r24) : (r24 + 34'(hs.k));
    assign sc    = 26'((tn + 34'sd128) >>> 8);
    assign fsum  = {prod_reg[37:0], 2'b00} + 40'd32768;

    always_comb
    begin
        case (state_reg)
            C_NUM:
            begin
                mul_a = 33'({18'd0, cutoff_reg});
                mul_b = 33'({21'd0, PI_FRAC});
            end
            C_FBM:
            begin
                mul_a = 33'({16'd0, res_reg});
                mul_b = 33'({13'd0, c16_reg});
            end
            default:
            begin
                mul_a = 33'({6'd0, quo_reg});
                mul_b = hs.use_b ? 33'(hs.b_k) : 33'(t_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cutoff_next = cutoff_reg;
        res_next    = res_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        t_next      = t_reg;
        prod_next   = prod_reg;
        c16_next    = c16_reg;
        gain_next   = gain_reg;
        fb_next     = fb_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cfg_valid && cfg_index == REG_CUTOFF)
                begin
                    cutoff_next = cfg_data[14:0];
                    state_next  = C_NUM;
                end
                else if (cfg_valid && cfg_index == REG_RESONANCE)
                begin
                    res_next   = cfg_data[16:0];
                    state_next = C_NUM;
                end
            end
            C_NUM:
            begin
                num_next   = mul_p[26:0] + 27'd12000;
                state_next = C_DIV;
            end
            C_DIV:
            begin
                quo_next   = xq;
                step_next  = '0;
                state_next = C_MUL;
            end
            C_MUL:
            begin
                prod_next  = mul_p;
                state_next = C_ADD;
            end
            C_ADD:
            begin
                t_next    = tn[31:0];
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    if (sc < 26'sd0)
                    begin
                        gain_next = '0;
                    end
                    else if (sc > 26'sd262143)
                    begin
                        gain_next = '1;
                    end
                    else
                    begin
                        gain_next = sc[17:0];
                    end
                end
                if (step_reg == 3'd6)
                begin
                    c16_next   = (sc < 26'sd0) ? 20'd0 : sc[19:0];
                    state_next = C_FBM;
                end
                else
                begin
                    state_next = C_MUL;
                end
            end
            C_FBM:
            begin
                prod_next  = mul_p;
                state_next = C_FBA;
            end
            C_FBA:
            begin
                fb_next    = (|fsum[39:36]) ? 20'hfffff : fsum[35:16];
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_NUM;
            cutoff_reg <= CUTOFF_RESET;
            res_reg    <= '0;
            gain_reg   <= '0;
            fb_reg     <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cutoff_reg <= cutoff_next;
            res_reg    <= res_next;
            gain_reg   <= gain_next;
            fb_reg     <= fb_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        t_reg    <= t_next;
        prod_reg <= prod_next;
        c16_reg  <= c16_next;
    end

    assign cfg_ready = (state_reg == C_IDLE);
    assign coef.gain = gain_reg;
    assign coef.fb   = fb_reg;

endmodule

>>> hw/rtl/sll_lane.sv
// ----------------------------------------------------------------------------
// sll_lane: one channel of the ladder
// Runs the feedback and the stages of one channel in turn over a shared
// multiplier and a two-digit divide by thirteen.
// ----------------------------------------------------------------------------
module sll_lane
    import sll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               ack,
    input  logic signed [23:0] sample,
    input  coef_t              coef,
    output lane_stat_t         stat
);

    typedef enum logic [7:0] {
        L_IDLE = 8'b00000001,
        L_FBM  = 8'b00000010,
        L_FBA  = 8'b00000100,
        L_DIVH = 8'b00001000,
        L_DIVL = 8'b00010000,
        L_GM   = 8'b00100000,
        L_GA   = 8'b01000000,
        L_DONE = 8'b10000000
    } lstate_t;

    lstate_t            state_reg, state_next;
    logic [STG_W-1:0]   stg_reg, stg_next;
    logic signed [31:0] u_reg, u_next;
    logic signed [31:0] x_reg, x_next;
    logic [17:0]        q1_reg, q1_next;
    logic [3:0]         r1_reg, r1_next;
    logic signed [31:0] mix_reg, mix_next;
    logic signed [53:0] prod_reg, prod_next;
    logic signed [31:0] pa_reg [NUM_STAGES];
    logic signed [31:0] pb_reg [NUM_STAGES];

    logic signed [31:0] pa_cur, pb_cur, ylast, y_sat;
    logic signed [37:0] n_sum;
    logic [35:0]        n_u;
    div13_t             dh, dl;
    logic [31:0]        q_lo;
    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] mul_p;
    logic signed [37:0] shifted;
    logic signed [28:0] o_sh;
    logic               wr_stage;

    assign pa_cur  = pa_reg[stg_reg];
    assign pb_cur  = pb_reg[stg_reg];
    assign ylast   = pb_reg[NUM_STAGES-1];
    assign n_sum   = 38'(x_reg) * 38'sd10 + 38'(pa_cur) * 38'sd3 + 38'sd6 + DIV_OFS;
    assign n_u     = n_sum[35:0];
    assign dh      = div13_step({4'd0, n_u[35:18]});
    assign dl      = div13_step({r1_reg, n_u[17:0]});
    assign q_lo    = {q1_reg[13:0], dl.q};
    assign mul_p   = 54'(mul_a) * 54'(mul_b);
    assign shifted = 38'((prod_reg + 54'sd32768) >>> 16);
    assign y_sat   = sat32(39'(pb_cur) + 39'(shifted));
    assign o_sh    = 29'((33'(x_reg) + 33'sd8) >>> 4);

    always_comb
    begin
        if (state_reg == L_FBM)
        begin
            mul_a = 33'(ylast) - 33'(u_reg >>> 1);
            mul_b = 21'({1'b0, coef.fb});
        end
        else
        begin
            mul_a = 33'(mix_reg) - 33'(pb_cur);
            mul_b = 21'({3'b000, coef.gain});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stg_next   = stg_reg;
        u_next     = u_reg;
        x_next     = x_reg;
        q1_next    = q1_reg;
        r1_next    = r1_reg;
        mix_next   = mix_reg;
        prod_next  = prod_reg;
        wr_stage   = 1'b0;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    u_next     = {{4{sample[23]}}, sample, 4'b0000};
                    state_next = L_FBM;
                end
            end
            L_FBM:
            begin
                prod_next  = mul_p;
                state_next = L_FBA;
            end
            L_FBA:
            begin
                x_next     = sat32(39'(u_reg) - 39'(shifted));
                stg_next   = '0;
                state_next = L_DIVH;
            end
            L_DIVH:
            begin
                q1_next    = dh.q;
                r1_next    = dh.r;
                state_next = L_DIVL;
            end
            L_DIVL:
            begin
                // quotient minus 2^31 taken modulo 2^32
                mix_next   = {~q_lo[31], q_lo[30:0]};
                state_next = L_GM;
            end
            L_GM:
            begin
                prod_next  = mul_p;
                state_next = L_GA;
            end
            L_GA:
            begin
                wr_stage = 1'b1;
                x_next   = y_sat;
                if (stg_reg == STG_W'(NUM_STAGES - 1))
                begin
                    state_next = L_DONE;
                end
                else
                begin
                    stg_next   = stg_reg + STG_W'(1);
                    state_next = L_DIVH;
                end
            end
            L_DONE:
            begin
                if (ack)
                begin
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            stg_reg   <= '0;
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                pa_reg[i] <= '0;
                pb_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            stg_reg   <= stg_next;
            if (wr_stage)
            begin
                pa_reg[stg_reg] <= x_reg;
                pb_reg[stg_reg] <= y_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        x_reg    <= x_next;
        q1_reg   <= q1_next;
        r1_reg   <= r1_next;
        mix_reg  <= mix_next;
        prod_reg <= prod_next;
    end

    assign stat.busy   = (state_reg != L_IDLE);
    assign stat.done   = (state_reg == L_DONE);
    assign stat.result = sat24(o_sh);

endmodule

>>> hw/rtl/sll_checker.sv
// ----------------------------------------------------------------------------
// sll_checker: port-level checks
// Watches the ports of the ladder low-pass over time.
// ----------------------------------------------------------------------------
module sll_checker
    import sll_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input in_beat_t              in_data,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_beat_t             out_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // held beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed under stall");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepted beat");

    a_derive_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_CUTOFF || cfg_index == REG_RESONANCE)
        |=> !cfg_ready)
        else $error("register write did not start derivation");

    a_stall_while_derive: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("input open while coefficients change");

endmodule

bind stereo_ladder_lowpass sll_checker u_sll_checker (.*);

>>> tb/tb_stereo_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// tb_stereo_ladder_lowpass: self-checking bench for the stereo ladder low-pass
// Drives sample pairs with random gaps, stalls the output side at random and
// compares every output beat with a bit-exact fixed-point filter predictor.
// Cutoff and resonance are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_stereo_ladder_lowpass
    import sll_pkg::*;
();

    localparam longint PI_K = 52707179;
    localparam longint G1 = 16596022, G2 = 7284667, G3 = 2316934, G4 = 338900;
    localparam longint C0 = 16825870, C1 = 882482, C2 = 1553570, C3 = 365744;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    longint    lp_prev_in[NUM_CHANNELS][NUM_STAGES];
    longint    lp_stage_y[NUM_CHANNELS][NUM_STAGES];
    longint    lp_gain;
    longint    lp_fb;
    longint    cur_cutoff;
    longint    cur_reso;
    out_beat_t filtered_q[$];
    int        errors;
    int        idle_cycles;
    bit        hold_output;
    bit        random_stall;

    stereo_ladder_lowpass DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint qmul24(longint a, longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic derive_coefs();
        longint x;
        longint t;
        x = (cur_cutoff * PI_K + 12000) / 24000;
        t = G3 - qmul24(x, G4);
        t = qmul24(x, t) - G2;
        t = qmul24(x, t) + G1;
        t = qmul24(x, t);
        lp_gain = clip((t + 128) >>> 8, 0, (64'sd1 <<< 18) - 1);
        t = qmul24(x, C3) - C2;
        t = qmul24(x, t) + C1;
        t = qmul24(x, t) + C0;
        t = (t + 128) >>> 8;
        if (t < 0)
        begin
            t = 0;
        end
        t = (4 * cur_reso * t + (64'sd1 <<< 15)) >>> 16;
        lp_fb = clip(t, 0, (64'sd1 <<< 20) - 1);
    endtask

    function automatic longint floor_div13(longint n);
        if (n >= 0)
        begin
            return n / 13;
        end
        return -((-n + 12) / 13);
    endfunction

    function automatic logic signed [23:0] ladder_channel(int ch, logic signed [23:0] smp);
        longint u;
        longint fbt;
        longint x;
        longint mix;
        longint y;
        u = longint'(smp) * 16;
        fbt = ((lp_stage_y[ch][NUM_STAGES-1] - (u >>> 1)) * lp_fb + (64'sd1 <<< 15)) >>> 16;
        x = clip(u - fbt, S32_MIN, S32_MAX);
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            mix = floor_div13(10 * x + 3 * lp_prev_in[ch][s] + 6);
            y = lp_stage_y[ch][s]
                + (((mix - lp_stage_y[ch][s]) * lp_gain + (64'sd1 <<< 15)) >>> 16);
            lp_stage_y[ch][s] = clip(y, S32_MIN, S32_MAX);
            lp_prev_in[ch][s] = x;
            x = lp_stage_y[ch][s];
        end
        return 24'(clip((x + 8) >>> 4, -8388608, 8388607));
    endfunction

    task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
        out_beat_t e;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        e.left_out = ladder_channel(0, l);
        e.right_out = (NUM_CHANNELS > 1) ? ladder_channel(1, r) : '0;
        filtered_q = {filtered_q, e};
        in_valid <= 1'b1;
        in_data.left_in <= l;
        in_data.right_in <= r;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_CUTOFF)
        begin
            cur_cutoff = val & 64'h7fff;
        end
        else if (idx == REG_RESONANCE)
        begin
            cur_reso = val & 64'h1ffff;
        end
        derive_coefs();
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 255)) - 24'sd128;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic signed [23:0] vals[6];
        vals = '{24'sh7fffff, 24'sh800000, 24'sd0, 24'sh555555, 24'shaaaaaa, -24'sd1};
        for (int i = 0; i < 6; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                send_pair(vals[i], vals[5 - i]);
            end
        end
    endtask

    task automatic test_config_extremes();
        write_reg(REG_CUTOFF, 24000);
        write_reg(REG_RESONANCE, 65536);
        repeat (6) send_pair(24'sh7fffff, 24'sh800000);
        repeat (6) send_pair(24'sh800000, 24'sh7fffff);
        write_reg(REG_CUTOFF, 32767);
        write_reg(REG_RESONANCE, 131071);
        repeat (8) send_pair(rand_sample(), rand_sample());
        write_reg(REG_CUTOFF, 0);
        write_reg(REG_RESONANCE, 0);
        repeat (4) send_pair(rand_sample(), rand_sample());
        write_reg(REG_UNUSED, 12345);
        repeat (2) send_pair(rand_sample(), rand_sample());
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_CUTOFF, $urandom_range(20, 24000));
            write_reg(REG_RESONANCE, $urandom_range(0, 65536));
            repeat (50) send_pair(rand_sample(), rand_sample());
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_CUTOFF, 2000);
        write_reg(REG_RESONANCE, 40000);
        fork
            begin
                hold_output = 1'b1;
                repeat (300) @(posedge clk);
                hold_output = 1'b0;
            end
            repeat (20) send_pair(rand_sample(), rand_sample());
        join
        drain();
        random_stall = 1'b0;
        repeat (40) send_pair(rand_sample(), rand_sample());
        random_stall = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_output)
        begin
            out_stall <= 1'b1;
        end
        else if (!random_stall)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, out_data);
                errors++;
            end
            else
            begin
                e = filtered_q.pop_front();
                if (out_data.left_out !== e.left_out)
                begin
                    $display("%0t: left_out expected %0d actual %0d",
                             $time, e.left_out, out_data.left_out);
                    errors++;
                end
                if (out_data.right_out !== e.right_out)
                begin
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, e.right_out, out_data.right_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_output = 1'b0;
        random_stall = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                lp_prev_in[c][s] = 0;
                lp_stage_y[c][s] = 0;
            end
        end
        cur_cutoff = 440;
        cur_reso = 0;
        derive_coefs();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_config_extremes();
        test_backpressure();
        test_random_settings();
        drain();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
